>>> hdl/imuvi_pkg.sv
package imuvi_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int VEL_W    = 32;
  localparam int MEAN_W   = SAMPLE_W + 1;
  localparam int ADB_W    = 15;
  localparam int VDB_W    = 31;
  localparam int CFG_W    = 31;
  localparam int AXES     = 3;

  // Register reset values (0.07 and 0.3 in units of 2^-12)
  localparam logic [ADB_W-1:0] ADB_RESET = 15'd287;
  localparam logic [VDB_W-1:0] VDB_RESET = 31'd1229;

  typedef enum logic [2:0] {
    REG_CAL_X = 3'd0,
    REG_CAL_Y = 3'd1,
    REG_CAL_Z = 3'd2,
    REG_ADB   = 3'd3,
    REG_VDB   = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_UPD,
    S_DIV_START,
    S_DIV_WAIT,
    S_ADD,
    S_SUB,
    S_DONE
  } state_t;

endpackage

>>> hdl/imuvi_ram.sv
module imuvi_ram #(
  parameter int DATA_W = 48,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/imuvi_div.sv
module imuvi_div #(
  parameter int DVD_W = 20,
  parameter int DVS_W = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0]        divisor,
  output logic                    done,
  output logic signed [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] dvs;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   trial;
  logic             fits;

  // One restoring step: shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem, quo[DVD_W-1]};
    fits  = trial >= {1'b0, dvs};
  end

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(DVD_W);
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
      dvs <= divisor;
      neg <= dividend[DVD_W-1];
    end else if (cnt != '0) begin
      rem <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  // Truncate toward zero: magnitude quotient takes the dividend's sign
  assign quotient = neg ? -$signed(quo) : $signed(quo);

endmodule

>>> hdl/imu_velocity_integrator_unit.sv
// Three-axis trapezoidal velocity integrator. Each input beat carries one
// accelerometer sample (Q3.12); each output beat carries the updated velocity
// of all three axes (Q19.12, saturating). The time a sample takes is set by
// the single bit-serial divider that forms the window mean, one quotient bit
// per cycle, shared by the three axes in turn. The input is not ready while
// a sample is in work; the next sample is taken while the last result still
// waits on the output. The sample window lives in a RAM and needs no clearing
// after reset.
module imu_velocity_integrator_unit
  import imuvi_pkg::*;
#(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] accel_x,
  input  logic signed [SAMPLE_W-1:0] accel_y,
  input  logic signed [SAMPLE_W-1:0] accel_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [VEL_W-1:0]    vel_x,
  output logic signed [VEL_W-1:0]    vel_y,
  output logic signed [VEL_W-1:0]    vel_z
);

  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = SAMPLE_W + PTR_W;
  localparam int WIN_W = SAMPLE_W * AXES;

  // Configuration registers
  logic signed [SAMPLE_W-1:0] cal [AXES];
  logic [ADB_W-1:0]           adb;
  logic [VDB_W-1:0]           vdb;

  // Sequencer and working state
  state_t                     state, state_next;
  logic [1:0]                 ax;
  logic signed [SAMPLE_W-1:0] raw [AXES];
  logic signed [SAMPLE_W-1:0] acc [AXES];
  logic signed [SAMPLE_W-1:0] acc_next [AXES];
  logic signed [SAMPLE_W-1:0] prev [AXES];
  logic signed [VEL_W-1:0]    vel [AXES];
  logic signed [SUM_W-1:0]    sums [AXES];
  logic [PTR_W-1:0]           wp;
  logic [CNT_W-1:0]           fill;
  logic                       full;
  logic signed [VEL_W-1:0]    v1;
  logic signed [MEAN_W-1:0]   mean;

  // Window RAM
  logic                       ram_we;
  logic [WIN_W-1:0]           ram_wdata;
  logic [WIN_W-1:0]           ram_rdata;

  // Divider
  logic                       div_start;
  logic                       div_done;
  logic signed [SUM_W-1:0]    div_q;

  // Shared per-axis arithmetic
  logic signed [SAMPLE_W:0]   trap_sum;
  logic signed [SAMPLE_W-1:0] trap;
  logic signed [VEL_W:0]      add_wide;
  logic signed [VEL_W-1:0]    add_sat;
  logic [VEL_W-1:0]           v1_mag;
  logic signed [VEL_W:0]      sub_wide;
  logic signed [VEL_W-1:0]    sub_sat;
  logic signed [VEL_W-1:0]    v2;

  logic                       out_free;

  assign full     = (fill == CNT_W'(WINDOW_DEPTH));
  assign out_free = !out_valid || out_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        cal[i] <= '0;
      end
      adb <= ADB_RESET;
      vdb <= VDB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CAL_X: cal[0] <= cfg_data[SAMPLE_W-1:0];
        REG_CAL_Y: cal[1] <= cfg_data[SAMPLE_W-1:0];
        REG_CAL_Z: cal[2] <= cfg_data[SAMPLE_W-1:0];
        REG_ADB:   adb    <= cfg_data[ADB_W-1:0];
        REG_VDB:   vdb    <= cfg_data[VDB_W-1:0];
        default: ;
      endcase
    end
  end

  // Calibrate, saturate and deadband each axis
  always_comb begin
    logic signed [SAMPLE_W:0] d;
    logic signed [SAMPLE_W-1:0] s;
    logic [SAMPLE_W-1:0] m;
    for (int i = 0; i < AXES; i++) begin
      d = (SAMPLE_W+1)'(raw[i]) - (SAMPLE_W+1)'(cal[i]);
      if (d[SAMPLE_W] != d[SAMPLE_W-1]) begin
        s = d[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
        s = d[SAMPLE_W-1:0];
      end
      m = s[SAMPLE_W-1] ? SAMPLE_W'(-s) : SAMPLE_W'(s);
      acc_next[i] = (m < {1'b0, adb}) ? '0 : s;
    end
  end

  // Trapezoid and velocity update for the current axis
  always_comb begin
    trap_sum = (SAMPLE_W+1)'(acc[ax]) + (SAMPLE_W+1)'(prev[ax]);
    trap     = SAMPLE_W'((trap_sum + (SAMPLE_W+1)'(trap_sum[SAMPLE_W])) >>> 1);
    add_wide = (VEL_W+1)'(vel[ax]) + (VEL_W+1)'(trap);
    if (add_wide[VEL_W] != add_wide[VEL_W-1]) begin
      add_sat = add_wide[VEL_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
    end else begin
      add_sat = add_wide[VEL_W-1:0];
    end
    v1_mag   = v1[VEL_W-1] ? VEL_W'(-v1) : VEL_W'(v1);
    sub_wide = (VEL_W+1)'(v1) - (VEL_W+1)'(mean);
    if (sub_wide[VEL_W] != sub_wide[VEL_W-1]) begin
      sub_sat = sub_wide[VEL_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
    end else begin
      sub_sat = sub_wide[VEL_W-1:0];
    end
    v2 = (v1_mag < {1'b0, vdb}) ? '0 : sub_sat;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_valid) state_next = S_PREP;
      S_PREP:      state_next = S_UPD;
      S_UPD:       state_next = S_DIV_START;
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT:  if (div_done) state_next = S_ADD;
      S_ADD:       state_next = S_SUB;
      S_SUB:       state_next = (ax == 2'd2) ? S_DONE : S_DIV_START;
      S_DONE:      if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = (state == S_IDLE);
    ram_we    = (state == S_UPD);
    div_start = (state == S_DIV_START);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the sample beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      raw[0] <= accel_x;
      raw[1] <= accel_y;
      raw[2] <= accel_z;
    end
  end

  // Window bookkeeping and per-axis velocity state
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
      ax   <= '0;
      for (int i = 0; i < AXES; i++) begin
        sums[i] <= '0;
        prev[i] <= '0;
        vel[i]  <= '0;
      end
    end else begin
      unique case (state)
        S_PREP: begin
          for (int i = 0; i < AXES; i++) begin
            acc[i] <= acc_next[i];
          end
          // Still accel on every axis: drop the velocities
          if (acc_next[0] == '0 && acc_next[1] == '0 && acc_next[2] == '0) begin
            for (int i = 0; i < AXES; i++) begin
              vel[i] <= '0;
            end
          end
          ax <= '0;
        end
        S_UPD: begin
          for (int i = 0; i < AXES; i++) begin
            sums[i] <= sums[i] + SUM_W'(acc[i])
                       - (full ? SUM_W'($signed(ram_rdata[i*SAMPLE_W +: SAMPLE_W])) : '0);
          end
          wp <= (wp == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp + PTR_W'(1);
          if (!full) begin
            fill <= fill + CNT_W'(1);
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            mean <= div_q[MEAN_W-1:0];
          end
        end
        S_ADD: begin
          v1 <= add_sat;
        end
        S_SUB: begin
          vel[ax]  <= v2;
          prev[ax] <= acc[ax];
          ax       <= ax + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      vel_x <= vel[0];
      vel_y <= vel[1];
      vel_z <= vel[2];
    end
  end

  assign ram_wdata = {acc[2], acc[1], acc[0]};

  imuvi_ram #(
    .DATA_W(WIN_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp),
    .wdata(ram_wdata),
    .raddr(wp),
    .rdata(ram_rdata)
  );

  imuvi_div #(
    .DVD_W(SUM_W),
    .DVS_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sums[ax]),
    .divisor (fill),
    .done    (div_done),
    .quotient(div_q)
  );

endmodule

>>> test/tb_imu_velocity_integrator_unit.sv
module tb_imu_velocity_integrator_unit
  import imuvi_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_DEPTH   = 16;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 180;
  localparam int IDLE_SETTLE = 4;
  localparam int END_SETTLE  = 100;
  localparam int REG_SPARE_LAST = 7;
  localparam logic [2:0] REG_SPARE_FIRST = 3'(REG_VDB) + 3'd1;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
  localparam logic [ADB_W-1:0]    ADB_MAX    = '1;
  localparam logic [VDB_W-1:0]    VDB_MAX    = '1;
  localparam longint VEL_MAX = 64'sd2147483647;
  localparam longint VEL_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [VEL_W-1:0] x;
    logic signed [VEL_W-1:0] y;
    logic signed [VEL_W-1:0] z;
  } vel_beat_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] accel_x = '0;
  logic signed [SAMPLE_W-1:0] accel_y = '0;
  logic signed [SAMPLE_W-1:0] accel_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] vel_z;

  // Velocity beats predicted for accepted samples, oldest first
  vel_beat_t expected_vel[$];
  int mismatch_count = 0;
  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;

  // Integrator state mirrored on the testbench side
  logic signed [SAMPLE_W-1:0] win_mem [WIN_DEPTH][AXES];
  int     wr_ptr;
  int     fill_cnt;
  longint win_sum [AXES];
  longint prev_acc [AXES];
  longint vel_acc [AXES];
  longint cal_reg [AXES];
  longint adb_reg;
  longint vdb_reg;

  imu_velocity_integrator_unit #(
    .WINDOW_DEPTH(WIN_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .accel_x   (accel_x),
    .accel_y   (accel_y),
    .accel_z   (accel_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .vel_z     (vel_z)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat_vel(input longint v);
    if (v > VEL_MAX) return VEL_MAX;
    if (v < VEL_MIN) return VEL_MIN;
    return v;
  endfunction

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void clear_integrator();
    wr_ptr   = 0;
    fill_cnt = 0;
    adb_reg  = longint'(ADB_RESET);
    vdb_reg  = longint'(VDB_RESET);
    for (int i = 0; i < AXES; i++) begin
      win_sum[i]  = 0;
      prev_acc[i] = 0;
      vel_acc[i]  = 0;
      cal_reg[i]  = 0;
    end
  endfunction

  // Advance the mirrored integrator by one sample and return the new velocities
  function automatic vel_beat_t integrate_sample(input logic signed [SAMPLE_W-1:0] ax,
                                                 input logic signed [SAMPLE_W-1:0] ay,
                                                 input logic signed [SAMPLE_W-1:0] az);
    longint raw [AXES];
    longint acc [AXES];
    longint mean;
    longint trap;
    longint v;
    logic [VEL_W-1:0] res [AXES];
    vel_beat_t beat;
    raw[0] = ax;
    raw[1] = ay;
    raw[2] = az;

    // Remove calibration, saturate to the sample range, apply deadband
    for (int i = 0; i < AXES; i++) begin
      acc[i] = raw[i] - cal_reg[i];
      if (acc[i] > 32767) acc[i] = 32767;
      if (acc[i] < -32768) acc[i] = -32768;
      if (magnitude(acc[i]) < adb_reg) acc[i] = 0;
    end

    // A quiet sample on all axes means the unit is at rest
    if (acc[0] == 0 && acc[1] == 0 && acc[2] == 0) begin
      for (int i = 0; i < AXES; i++) vel_acc[i] = 0;
    end

    // Push into the sliding window, dropping the oldest entry once full
    for (int i = 0; i < AXES; i++) begin
      if (fill_cnt >= WIN_DEPTH) win_sum[i] -= win_mem[wr_ptr][i];
      win_mem[wr_ptr][i] = acc[i][SAMPLE_W-1:0];
      win_sum[i] += acc[i];
    end
    wr_ptr = (wr_ptr + 1) % WIN_DEPTH;
    if (fill_cnt < WIN_DEPTH) fill_cnt++;

    // Trapezoid step, velocity deadband, then remove the window mean
    for (int i = 0; i < AXES; i++) begin
      mean = win_sum[i] / longint'(fill_cnt);
      trap = (acc[i] + prev_acc[i]) / 2;
      v = sat_vel(vel_acc[i] + trap);
      if (magnitude(v) < vdb_reg) v = 0;
      else v = sat_vel(v - mean);
      vel_acc[i]  = v;
      prev_acc[i] = acc[i];
      res[i] = v[VEL_W-1:0];
    end
    beat.x = res[0];
    beat.y = res[1];
    beat.z = res[2];
    return beat;
  endfunction

  // Idle lengths: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Output backpressure
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!sink_steady && $urandom_range(0, 99) < 30) stall_left = idle_len();
      end
    end
  end

  // Compare each velocity beat against the oldest prediction
  always @(posedge clk) begin
    vel_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_vel.size() == 0) begin
        $error("velocity beat with no sample pending: x=%0d y=%0d z=%0d",
               vel_x, vel_y, vel_z);
        mismatch_count++;
      end else begin
        want = expected_vel.pop_front();
        if (vel_x !== want.x) begin
          $error("vel_x: expected %0d, got %0d", want.x, vel_x);
          mismatch_count++;
        end
        if (vel_y !== want.y) begin
          $error("vel_y: expected %0d, got %0d", want.y, vel_y);
          mismatch_count++;
        end
        if (vel_z !== want.z) begin
          $error("vel_z: expected %0d, got %0d", want.z, vel_z);
          mismatch_count++;
        end
      end
    end
  end

  // Offer one sample beat, hold it until taken, then maybe idle
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] ax,
                             input logic signed [SAMPLE_W-1:0] ay,
                             input logic signed [SAMPLE_W-1:0] az);
    int gap;
    in_valid <= 1'b1;
    accel_x  <= ax;
    accel_y  <= ay;
    accel_z  <= az;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_vel.push_back(integrate_sample(ax, ay, az));
    gap = 0;
    if (!src_steady && $urandom_range(0, 99) >= 55) gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every predicted beat has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_vel.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CAL_X: cal_reg[0] = $signed(data[SAMPLE_W-1:0]);
      REG_CAL_Y: cal_reg[1] = $signed(data[SAMPLE_W-1:0]);
      REG_CAL_Z: cal_reg[2] = $signed(data[SAMPLE_W-1:0]);
      REG_ADB:   adb_reg = longint'(data[ADB_W-1:0]);
      REG_VDB:   vdb_reg = longint'(data[VDB_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Write all registers; unused upper data bits get random junk
  task automatic program_config(input logic [SAMPLE_W-1:0] cx,
                                input logic [SAMPLE_W-1:0] cy,
                                input logic [SAMPLE_W-1:0] cz,
                                input logic [ADB_W-1:0] adb,
                                input logic [VDB_W-1:0] vdb);
    write_reg(REG_CAL_X, {15'($urandom), cx});
    write_reg(REG_CAL_Y, {15'($urandom), cy});
    write_reg(REG_CAL_Z, {15'($urandom), cz});
    write_reg(REG_ADB, {16'($urandom), adb});
    write_reg(REG_VDB, vdb);
  endtask

  // One axis value; quiet values stay inside the deadband after calibration
  function automatic logic signed [SAMPLE_W-1:0] pick_axis(input int a, input bit quiet);
    int lim;
    int offs;
    int r;
    lim = int'(adb_reg);
    if (quiet) begin
      offs = (lim > 0) ? int'($urandom_range(0, 2 * lim - 2)) - (lim - 1) : 0;
      return 16'(cal_reg[a] + offs);
    end
    r = $urandom_range(0, 99);
    if (r < 20) begin
      offs = int'($urandom_range(0, 2 * lim + 8)) - (lim + 4);
      return 16'(cal_reg[a] + offs);
    end
    if (r < 50) return 16'(int'($urandom_range(0, 8000)) - 4000);
    if (r < 58) begin
      case ($urandom_range(0, 3))
        0: return SAMPLE_MIN;
        1: return SAMPLE_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    return 16'($urandom);
  endfunction

  task automatic test_first_sample_and_deadbands();
    // odd first sample checks the halving with a zero predecessor
    send_sample(16'sd1001, -16'sd1001, 16'sd4097);
    send_sample(16'sd286, -16'sd286, 16'sd287);
    send_sample(-16'sd287, 16'sd287, $signed(SAMPLE_MIN));
    send_sample($signed(SAMPLE_MAX), -16'sd3, 16'sd5);
    // all axes inside the deadband: velocities clear
    send_sample(16'sd0, 16'sd100, -16'sd200);
    send_sample(-16'sd5000, 16'sd2999, 16'sd0);
  endtask

  task automatic test_calibration_saturation();
    wait_idle();
    program_config(SAMPLE_MIN, SAMPLE_MAX, 16'd12345, ADB_RESET, VDB_RESET);
    send_sample($signed(SAMPLE_MAX), $signed(SAMPLE_MIN), 16'sd0);
    send_sample($signed(SAMPLE_MIN), $signed(SAMPLE_MAX), 16'sd12345);
    send_sample(16'sd100, -16'sd100, -16'sd20000);
  endtask

  task automatic test_deadband_extremes();
    // zero deadbands never zero anything
    wait_idle();
    program_config('0, '0, '0, '0, '0);
    send_sample(16'sd0, 16'sd0, 16'sd1);
    send_sample(-16'sd1, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd0);
    // widest deadbands: only the two largest magnitudes get through
    wait_idle();
    program_config('0, '0, '0, ADB_MAX, VDB_MAX);
    send_sample($signed(SAMPLE_MAX), -16'sd32767, $signed(SAMPLE_MIN));
    send_sample(16'sd32766, -16'sd32766, $signed(SAMPLE_MAX));
    send_sample($signed(SAMPLE_MIN), $signed(SAMPLE_MIN), $signed(SAMPLE_MIN));
  endtask

  task automatic test_unused_register_index();
    wait_idle();
    program_config('0, '0, '0, ADB_RESET, 31'd50);
    // writes past the last register must leave the setup alone
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++) write_reg(3'(i), 31'($urandom));
    send_sample(16'sd3000, -16'sd7000, 16'sd150);
    send_sample(16'sd2500, -16'sd6900, 16'sd400);
  endtask

  task automatic pick_phase_config(input int p);
    logic [SAMPLE_W-1:0] cal [AXES];
    logic [ADB_W-1:0] adb;
    logic [VDB_W-1:0] vdb;
    int r;
    for (int a = 0; a < AXES; a++) begin
      r = $urandom_range(0, 9);
      if (r < 6) cal[a] = 16'(int'($urandom_range(0, 1000)) - 500);
      else if (r < 8) cal[a] = $urandom_range(0, 1) ? SAMPLE_MIN : SAMPLE_MAX;
      else cal[a] = 16'($urandom);
    end
    r = $urandom_range(0, 9);
    if (r == 0) adb = '0;
    else if (r == 1) adb = ADB_MAX;
    else if (r < 7) adb = 15'($urandom_range(0, 600));
    else adb = 15'($urandom);
    r = $urandom_range(0, 9);
    if (r == 0) vdb = '0;
    else if (r == 1) vdb = VDB_MAX;
    else if (r < 6) vdb = 31'($urandom_range(0, 5000));
    else if (r < 9) vdb = 31'($urandom_range(0, 300000));
    else vdb = 31'($urandom);
    case (p)
      0: program_config('0, '0, '0, ADB_RESET, VDB_RESET);
      1: program_config(SAMPLE_MIN, SAMPLE_MAX, cal[2], adb, vdb);
      2: program_config(cal[0], cal[1], cal[2], '0, '0);
      3: program_config(cal[0], cal[1], cal[2], ADB_MAX, VDB_MAX);
      default: program_config(cal[0], cal[1], cal[2], adb, vdb);
    endcase
  endtask

  task automatic test_random_traffic();
    logic signed [SAMPLE_W-1:0] smp [AXES];
    bit quiet;
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      pick_phase_config(p);
      src_steady  = (p % 4 == 2);
      sink_steady = (p % 4 >= 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        quiet = ($urandom_range(0, 99) < 8);
        for (int a = 0; a < AXES; a++) smp[a] = pick_axis(a, quiet);
        send_sample(smp[0], smp[1], smp[2]);
        // now and then let the pipeline run dry
        if ($urandom_range(0, 149) == 0) wait_idle();
      end
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    clear_integrator();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_sample_and_deadbands();
    test_calibration_saturation();
    test_deadband_extremes();
    test_unused_register_index();
    test_random_traffic();

    wait_idle();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_imu_velocity_integrator_unit passed");
    end else begin
      $display("tb_imu_velocity_integrator_unit failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("tb_imu_velocity_integrator_unit failed");
    $finish;
  end

endmodule

>>> imu_velocity_integrator_unit.f
hdl/imuvi_pkg.sv
hdl/imuvi_ram.sv
hdl/imuvi_div.sv
hdl/imu_velocity_integrator_unit.sv
test/tb_imu_velocity_integrator_unit.sv
